/* design/dtq_pkg.sv */
// Types and constants shared by the deadline timer queue.
// Depends on nothing; the cell and the top level use it.
package dtq_pkg;

  localparam int unsigned DeadlineW = 63;
  localparam int unsigned TagW      = 32;
  localparam int unsigned FreqW     = 32;
  localparam int unsigned DelayW    = 31;

  localparam logic [FreqW-1:0]     FreqReset   = 32'd62500000;
  localparam logic [DeadlineW-1:0] DeadlineMax = {DeadlineW{1'b1}};

  localparam logic [1:0] FreqAddr = 2'd0;

  typedef enum logic {
    KindAdd    = 1'b0,
    KindExpire = 1'b1
  } dtq_kind_e;

  typedef struct packed {
    logic                 valid;
    logic [DeadlineW-1:0] deadline;
    logic [TagW-1:0]      tag;
  } dtq_entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } dtq_cmd_t;

endpackage

/* design/dtq_cell.sv */
// One cell of the sorted timer row: holds a single entry and passes it on.
// Depends on dtq_pkg for the entry and command types.
module dtq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtq_pkg::dtq_cmd_t   cmd_i,
  input  dtq_pkg::dtq_entry_t new_i,
  input  dtq_pkg::dtq_entry_t left_i,
  input  logic                left_le_i,
  input  dtq_pkg::dtq_entry_t right_i,
  output logic                le_o,
  output dtq_pkg::dtq_entry_t entry_o
);

  logic                          valid_q, valid_d;
  logic [dtq_pkg::DeadlineW-1:0] deadline_q, deadline_d;
  logic [dtq_pkg::TagW-1:0]      tag_q, tag_d;

  // An entry that is not later than the new one stays ahead of it, so ties keep arrival order.
  assign le_o = valid_q && (deadline_q <= new_i.deadline);

  always_comb begin
    valid_d    = valid_q;
    deadline_d = deadline_q;
    tag_d      = tag_q;
    if (cmd_i.pop) begin
      valid_d    = right_i.valid;
      deadline_d = right_i.deadline;
      tag_d      = right_i.tag;
    end else if (cmd_i.ins && !le_o) begin
      if (left_le_i) begin
        valid_d    = new_i.valid;
        deadline_d = new_i.deadline;
        tag_d      = new_i.tag;
      end else begin
        valid_d    = left_i.valid;
        deadline_d = left_i.deadline;
        tag_d      = left_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    tag_q      <= tag_d;
  end

  assign entry_o = '{valid: valid_q, deadline: deadline_q, tag: tag_q};

endmodule

/* design/deadline_timer_queue.sv */
// Top level of the deadline timer queue: APB register, deadline arithmetic and the cell row.
// Depends on dtq_pkg and dtq_cell.
//
// Each item goes through the multiplier stage, where the delay is multiplied by the counter
// frequency, and then the deadline is added and saturated and the row of cells,
// kept sorted by deadline and then by age, inserts or pops in a single step. The head
// cell always holds the comparator value. A new item is taken once the previous one has
// left the multiplier stage, and a finished result waits in the output register.
module deadline_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [dtq_pkg::DeadlineW-1:0] now_ticks_i,
  input  logic [dtq_pkg::DelayW-1:0]    delay_seconds_i,
  input  logic [dtq_pkg::TagW-1:0]      tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fired_o,
  output logic [dtq_pkg::TagW-1:0]      fired_tag_o,
  output logic [dtq_pkg::DeadlineW-1:0] compare_value_o,
  output logic                          compare_armed_o,
  output logic                          rejected_o,
  output logic                          schedule_request_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Configuration register.
  logic [dtq_pkg::FreqW-1:0] freq_q;

  assign pready = 1'b1;
  assign prdata = freq_q;

  // paddr only carries the byte offset within the single register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= dtq_pkg::FreqReset;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == dtq_pkg::FreqAddr)) begin
      freq_q <= pwdata;
    end
  end

  // Multiplier stage.
  logic                          s1_valid_q;
  dtq_pkg::dtq_kind_e            s1_kind_q;
  logic [dtq_pkg::DeadlineW-1:0] s1_now_q;
  logic [dtq_pkg::TagW-1:0]      s1_tag_q;
  logic [dtq_pkg::DeadlineW-1:0] s1_prod_q;
  logic                          in_accept;
  logic                          advance;
  logic                          out_valid_q;

  assign in_stall_o = s1_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= dtq_pkg::dtq_kind_e'(kind_i);
      s1_now_q  <= now_ticks_i;
      s1_tag_q  <= tag_i;
      s1_prod_q <= {32'd0, delay_seconds_i} * {31'd0, freq_q};
    end
  end

  // Deadline sum with saturation.
  logic [dtq_pkg::DeadlineW:0] sum;
  dtq_pkg::dtq_entry_t         new_entry;

  assign sum       = {1'b0, s1_prod_q} + {1'b0, s1_now_q};
  assign new_entry = '{
    valid:    1'b1,
    deadline: sum[dtq_pkg::DeadlineW] ? dtq_pkg::DeadlineMax : sum[dtq_pkg::DeadlineW-1:0],
    tag:      s1_tag_q
  };

  // Row of cells, head at index zero.
  dtq_pkg::dtq_entry_t entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le;
  dtq_pkg::dtq_cmd_t cmd;
  logic full, empty;

  assign full  = entries[QUEUE_DEPTH-1].valid;
  assign empty = !entries[0].valid;
  assign cmd.ins = advance && (s1_kind_q == dtq_pkg::KindAdd) && !full;
  assign cmd.pop = advance && (s1_kind_q == dtq_pkg::KindExpire) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dtq_pkg::dtq_entry_t left_entry, right_entry;
    logic left_le;

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_le    = 1'b1;
    end else begin : g_inner_left
      assign left_entry = entries[i-1];
      assign left_le    = le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_right
      assign right_entry = entries[i+1];
    end

    dtq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .new_i     (new_entry),
      .left_i    (left_entry),
      .left_le_i (left_le),
      .right_i   (right_entry),
      .le_o      (le[i]),
      .entry_o   (entries[i])
    );
  end

  // Pending count.
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Head of the row after this beat.
  dtq_pkg::dtq_entry_t head_next;

  always_comb begin
    head_next = entries[0];
    if (cmd.pop) begin
      head_next = entries[1];
    end else if (cmd.ins && !le[0]) begin
      head_next = new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fired_o            <= cmd.pop;
      fired_tag_o        <= cmd.pop ? entries[0].tag : '0;
      compare_value_o    <= head_next.valid ? head_next.deadline : '0;
      compare_armed_o    <= head_next.valid;
      rejected_o         <= (s1_kind_q == dtq_pkg::KindAdd) && full;
      schedule_request_o <= (s1_kind_q == dtq_pkg::KindExpire) && empty;
      pending_count_o    <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* verif/deadline_timer_queue_tb.sv */
// Self-checking testbench for deadline_timer_queue: directed and random timer adds and
// expiries under random idling, each result checked against a deadline queue kept here.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
module deadline_timer_queue_tb;
  import dtq_pkg::*;

  localparam int          QueueDepth  = 8;
  localparam int          CycleLimit  = 500000;
  localparam int          LongHold    = 300;
  localparam int          DrainCycles = 6;

  typedef enum int {IdleNone, IdleSparse, IdleHeavy} idle_mode_e;

  typedef struct packed {
    dtq_kind_e             kind;
    logic [DeadlineW-1:0]  now;
    logic [DelayW-1:0]     delay;
    logic [TagW-1:0]       tag;
  } timer_req_t;

  typedef struct packed {
    logic                  fired;
    logic [TagW-1:0]       fired_tag;
    logic [DeadlineW-1:0]  compare_value;
    logic                  compare_armed;
    logic                  rejected;
    logic                  schedule_request;
    logic [3:0]            pending_count;
  } timer_outcome_t;

  typedef struct {
    logic [DeadlineW-1:0] deadline;
    logic [TagW-1:0]      tag;
  } armed_timer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 apb_sel = 1'b0;
  logic                 apb_enable = 1'b0;
  logic                 apb_write = 1'b0;
  logic [1:0]           apb_addr = '0;
  logic [31:0]          apb_wdata = '0;
  logic [31:0]          apb_rdata;
  logic                 apb_ready;

  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 req_kind = 1'b0;
  logic [DeadlineW-1:0] req_now = '0;
  logic [DelayW-1:0]    req_delay = '0;
  logic [TagW-1:0]      req_tag = '0;

  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic                 res_fired;
  logic [TagW-1:0]      res_fired_tag;
  logic [DeadlineW-1:0] res_compare_value;
  logic                 res_compare_armed;
  logic                 res_rejected;
  logic                 res_schedule_request;
  logic [$clog2(QueueDepth+1)-1:0] res_pending_count;

  timer_req_t     request_q[$];
  timer_outcome_t outcome_q[$];
  armed_timer_t   armed_q[$];
  logic [FreqW-1:0] freq_shadow = FreqReset;

  timer_req_t     offered_req;
  timer_outcome_t oldest_outcome;
  idle_mode_e     send_mode = IdleNone;
  idle_mode_e     recv_mode = IdleNone;
  int             send_wait = 0;
  int             recv_wait = 0;
  int             hold_left = 0;
  bit             hold_trigger = 1'b0;
  bit             hold_used = 1'b0;
  int             fail_cnt = 0;
  int             cycle_cnt = 0;

  deadline_timer_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (apb_sel),
    .penable            (apb_enable),
    .pwrite             (apb_write),
    .paddr              (apb_addr),
    .pwdata             (apb_wdata),
    .prdata             (apb_rdata),
    .pready             (apb_ready),
    .in_valid_i         (req_valid),
    .in_stall_o         (req_stall),
    .kind_i             (req_kind),
    .now_ticks_i        (req_now),
    .delay_seconds_i    (req_delay),
    .tag_i              (req_tag),
    .out_valid_o        (res_valid),
    .out_stall_i        (res_stall),
    .fired_o            (res_fired),
    .fired_tag_o        (res_fired_tag),
    .compare_value_o    (res_compare_value),
    .compare_armed_o    (res_compare_armed),
    .rejected_o         (res_rejected),
    .schedule_request_o (res_schedule_request),
    .pending_count_o    (res_pending_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int draw_wait(idle_mode_e mode);
    case (mode)
      IdleSparse: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      IdleHeavy:  return $urandom_range(0, 17);
      default:    return 0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Earliest deadline wins; the queue is in arrival order, so a strict compare keeps
  // the oldest of equal deadlines.
  function automatic int earliest_timer();
    int best;
    best = -1;
    foreach (armed_q[i]) begin
      if (best < 0 || armed_q[i].deadline < armed_q[best].deadline) best = i;
    end
    return best;
  endfunction

  function automatic timer_outcome_t step_timer_queue(timer_req_t req);
    timer_outcome_t res;
    armed_timer_t   entry;
    logic [63:0]    sum;
    int             head;
    res = '0;
    if (req.kind == KindAdd) begin
      if (armed_q.size() >= QueueDepth) begin
        res.rejected = 1'b1;
      end else begin
        sum = 64'(req.delay) * 64'(freq_shadow) + 64'(req.now);
        entry.deadline = (sum > 64'(DeadlineMax)) ? DeadlineMax : sum[DeadlineW-1:0];
        entry.tag = req.tag;
        armed_q.push_back(entry);
      end
    end else begin
      head = earliest_timer();
      if (head < 0) begin
        res.schedule_request = 1'b1;
      end else begin
        res.fired = 1'b1;
        res.fired_tag = armed_q[head].tag;
        armed_q.delete(head);
      end
    end
    head = earliest_timer();
    if (head >= 0) begin
      res.compare_value = armed_q[head].deadline;
      res.compare_armed = 1'b1;
    end
    res.pending_count = 4'(armed_q.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        outcome_q.push_back(step_timer_queue(offered_req));
      end
      if (!req_valid || !req_stall) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          req_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          offered_req = request_q.pop_front();
          req_kind  <= offered_req.kind;
          req_now   <= offered_req.now;
          req_delay <= offered_req.delay;
          req_tag   <= offered_req.tag;
          req_valid <= 1'b1;
          send_wait <= draw_wait(send_mode);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result beat arrived with no outcome outstanding");
          fail_cnt++;
        end else begin
          oldest_outcome = outcome_q.pop_front();
          check_field("fired", oldest_outcome.fired, res_fired);
          check_field("fired_tag", oldest_outcome.fired_tag, res_fired_tag);
          check_field("compare_value", oldest_outcome.compare_value, res_compare_value);
          check_field("compare_armed", oldest_outcome.compare_armed, res_compare_armed);
          check_field("rejected", oldest_outcome.rejected, res_rejected);
          check_field("schedule_request", oldest_outcome.schedule_request,
                      res_schedule_request);
          check_field("pending_count", oldest_outcome.pending_count, res_pending_count);
        end
        recv_wait = draw_wait(recv_mode);
      end
      if (hold_trigger && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL deadline_timer_queue");
      $finish;
    end
  end

  task automatic apb_access(input bit wr, input logic [1:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    apb_write  <= wr;
    apb_addr   <= addr;
    apb_wdata  <= wdata;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!apb_ready);
    rdata = apb_rdata;
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
  endtask

  task automatic set_frequency(input logic [31:0] value);
    logic [31:0] readback;
    apb_access(1'b1, FreqAddr, value, readback);
    freq_shadow = value;
    apb_access(1'b0, FreqAddr, '0, readback);
    check_field("counter_frequency", value, readback);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || req_valid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic push_req(input dtq_kind_e kind, input logic [DeadlineW-1:0] now,
                          input logic [DelayW-1:0] delay, input logic [TagW-1:0] tag);
    timer_req_t req;
    req.kind  = kind;
    req.now   = now;
    req.delay = delay;
    req.tag   = tag;
    request_q.push_back(req);
  endtask

  function automatic logic [DeadlineW-1:0] random_now();
    case ($urandom_range(0, 3))
      0:       return DeadlineW'($urandom_range(0, 1000));
      1:       return DeadlineMax - DeadlineW'($urandom_range(0, 1000));
      default: return DeadlineW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [DelayW-1:0] random_delay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2:    return DelayW'($urandom_range(0, 20));
      3:       return {DelayW{1'b1}};
      default: return DelayW'($urandom);
    endcase
  endfunction

  // Runs of adds and expiries with a drifting add ratio, so the queue swings between
  // empty and full; some adds repeat the previous add to force equal deadlines.
  task automatic queue_random(input int count);
    timer_req_t req;
    int add_pct;
    logic [DeadlineW-1:0] last_now;
    logic [DelayW-1:0] last_delay;
    add_pct = 50;
    last_now = '0;
    last_delay = '0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) add_pct = 30 + 20 * $urandom_range(0, 2);
      req.now   = random_now();
      req.delay = random_delay();
      req.tag   = $urandom;
      if ($urandom_range(0, 99) < add_pct) begin
        req.kind = KindAdd;
        if ($urandom_range(0, 5) == 0) begin
          req.now   = last_now;
          req.delay = last_delay;
        end
        last_now   = req.now;
        last_delay = req.delay;
      end else begin
        req.kind = KindExpire;
      end
      request_q.push_back(req);
    end
  endtask

  initial begin
    logic [31:0] readback;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_access(1'b0, FreqAddr, '0, readback);
    check_field("counter_frequency", FreqReset, readback);

    @(negedge clk_i);
    send_mode = IdleSparse;
    recv_mode = IdleSparse;
    push_req(KindExpire, '0, '0, '0);
    push_req(KindAdd, '0, '0, '0);
    push_req(KindAdd, DeadlineMax, {DelayW{1'b1}}, '1);
    push_req(KindAdd, 63'd5, 31'd1, 32'd1);
    push_req(KindAdd, 63'd5, 31'd1, 32'd2);
    push_req(KindAdd, 63'd62500005, '0, 32'd3);
    push_req(KindAdd, DeadlineMax, '0, 32'd4);
    push_req(KindAdd, 63'h5555_5555_5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
    push_req(KindAdd, 63'h2AAA_AAAA_AAAA_AAAA, 31'h5555_5555, 32'h5555_5555);
    push_req(KindAdd, 63'd9, 31'd0, 32'd9);
    for (int k = 0; k < 9; k++) push_req(KindExpire, DeadlineW'(k), '0, '0);
    push_req(KindAdd, 63'd1, '0, 32'd7);
    push_req(KindExpire, '0, '0, '0);
    wait_drained();

    set_frequency(32'd1);
    @(negedge clk_i);
    send_mode = IdleHeavy;
    recv_mode = IdleHeavy;
    queue_random(350);
    wait_drained();

    // The receiver holds off while the sender streams with no gaps, filling the block.
    set_frequency(32'hFFFF_FFFF);
    @(negedge clk_i);
    send_mode = IdleNone;
    recv_mode = IdleSparse;
    hold_trigger = 1'b1;
    queue_random(400);
    wait_drained();

    set_frequency($urandom_range(1, 32'hFFFF_FFFF));
    @(negedge clk_i);
    send_mode = IdleHeavy;
    recv_mode = IdleNone;
    queue_random(450);
    wait_drained();

    set_frequency($urandom_range(1, 50));
    @(negedge clk_i);
    send_mode = IdleSparse;
    recv_mode = IdleSparse;
    queue_random(700);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("PASS deadline_timer_queue");
    end else begin
      $display("FAIL deadline_timer_queue");
    end
    $finish;
  end

endmodule
